@@ design/rsr_pkg.sv @@
// shared constants, types and the divider step for the regularized spectrum reciprocal
package rsr_pkg;

  // data format: signed, DATA_WIDTH bits, FRAC_BITS fraction bits
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = DATA_WIDTH / 2;
  // denominator keeps 2*FRAC_BITS fraction bits and never reaches 2^(2*DATA_WIDTH)
  localparam int DEN_FRAC   = 2 * FRAC_BITS;
  localparam int DEN_W      = 2 * DATA_WIDTH;
  // numerator magnitude shifted up by the denominator fraction bits
  localparam int NUM_W      = DATA_WIDTH + DEN_FRAC;
  // multiplier operand split for the squares
  localparam int HALF_W     = DATA_WIDTH / 2;
  // front stages ahead of the divider setup: magnitude, partial products, squares, denominator
  localparam int DIV_FIRST  = 4;
  // front stages, divider setup, one divider stage per quotient bit, output register
  localparam int N_STAGES   = DIV_FIRST + DATA_WIDTH + 2;

  // configuration register file
  localparam int          GAMMA_W     = 32;
  localparam logic [31:0] GAMMA_RESET = 32'd429;
  localparam int          CFG_AW      = 3;
  localparam logic [0:0]  REG_GAMMA   = 1'b0;

  // one slot of the restoring divider, both lanes side by side
  typedef struct packed {
    logic [DEN_W-1:0]      den;
    logic                  dzero;
    logic [DEN_W-1:0]      rem_re;
    logic [DEN_W-1:0]      rem_im;
    logic [DATA_WIDTH-1:0] nlow_re;
    logic [DATA_WIDTH-1:0] nlow_im;
    logic [DATA_WIDTH-1:0] q_re;
    logic [DATA_WIDTH-1:0] q_im;
    logic                  ovf_re;
    logic                  ovf_im;
    logic                  neg_re;
    logic                  neg_im;
  } div_stage_t;

  // one restoring step: returns {quotient bit, new remainder}
  function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] den,
                                              input logic [DEN_W-1:0] rem,
                                              input logic             nbit);
    logic [DEN_W:0] shifted;
    logic [DEN_W:0] diff;
    logic           take;
    shifted = {rem, nbit};
    diff    = shifted - {1'b0, den};
    take    = (shifted >= {1'b0, den});
    div_step = take ? {1'b1, diff[DEN_W-1:0]} : {1'b0, shifted[DEN_W-1:0]};
  endfunction

endpackage

@@ design/regularized_spectrum_reciprocal.sv @@
// regularized complex reciprocal conj(z)/(|z|^2+gamma), fully pipelined
//
//  channel   ports                                       moves
//  in        in_valid/in_ready, in_real_part,            one coefficient request
//            in_imag_part, in_real_only
//  out       out_valid/out_ready, out_real, out_imag,    one result request
//            out_saturated
//  cfg       cfg_psel/penable/pwrite/paddr/pwdata,       gamma register (Q0.32)
//            cfg_prdata, cfg_pready
//
// one request per cycle while the output is not stalled
// the restoring divider has one stage per quotient bit in each of two lanes;
// ahead of it: magnitude, partial products, squares, denominator, divider setup
// reset (synchronous, rst_n low) clears all stage valid bits and loads gamma = 429
// a stalled output holds only the unbroken run of full stages next to it; stages above a bubble keep filling
module regularized_spectrum_reciprocal (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [rsr_pkg::DATA_WIDTH-1:0] in_real_part,
  input  logic signed [rsr_pkg::DATA_WIDTH-1:0] in_imag_part,
  input  logic                                  in_real_only,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [rsr_pkg::DATA_WIDTH-1:0] out_real,
  output logic signed [rsr_pkg::DATA_WIDTH-1:0] out_imag,
  output logic                                  out_saturated,
  // configuration port
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [rsr_pkg::CFG_AW-1:0]            cfg_paddr,
  input  logic [31:0]                           cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int W    = rsr_pkg::DATA_WIDTH;
  localparam int H    = rsr_pkg::HALF_W;
  localparam int HW   = W - H;
  localparam int DF   = rsr_pkg::DEN_FRAC;
  localparam int DNW  = rsr_pkg::DEN_W;
  localparam int NW   = rsr_pkg::NUM_W;
  localparam int NST  = rsr_pkg::N_STAGES;
  localparam int DV0  = rsr_pkg::DIV_FIRST;
  localparam int PLW  = W + H;
  localparam int PHW  = W + HW;
  localparam int SQW  = 2 * W;
  localparam int GW   = rsr_pkg::GAMMA_W;

  // configuration register
  logic [GW-1:0]  gamma_r;
  logic           cfg_wr;
  logic           cfg_hit;
  logic [DNW-1:0] gamma_al;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[rsr_pkg::CFG_AW-1:2] == rsr_pkg::REG_GAMMA);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_hit;
  assign cfg_prdata = cfg_hit ? gamma_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= rsr_pkg::GAMMA_RESET;
    end else if (cfg_wr) begin
      gamma_r <= cfg_pwdata[GW-1:0];
    end
  end

  // align gamma to the denominator fraction bits
  generate
    if (DF >= GW) begin : g_gam_up
      assign gamma_al = DNW'(gamma_r) << (DF - GW);
    end else begin : g_gam_dn
      assign gamma_al = DNW'(gamma_r >> (GW - DF));
    end
  endgenerate

  // stage valid bits and per-stage load enables
  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  generate
    for (genvar k = 0; k < NST; k++) begin : g_en
      assign en[k] = out_ready | ~(&v_r[NST-1:k]);
    end
  endgenerate

  assign in_ready  = en[0];
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 0: magnitudes and result signs
  logic [W-1:0] re_raw, im_raw, re_mag_nxt, im_mag_nxt;
  logic         neg_re_nxt, neg_im_nxt;
  logic [W-1:0] s0_re_mag_r, s0_im_mag_r;
  logic         s0_neg_re_r, s0_neg_im_r;

  always_comb begin
    re_raw     = in_real_part;
    im_raw     = in_real_only ? '0 : in_imag_part;
    re_mag_nxt = re_raw[W-1] ? (~re_raw + 1'b1) : re_raw;
    im_mag_nxt = im_raw[W-1] ? (~im_raw + 1'b1) : im_raw;
    neg_re_nxt = re_raw[W-1];
    // -im over the denominator: negative when im is positive
    neg_im_nxt = !im_raw[W-1] && (im_raw != '0);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_re_mag_r <= re_mag_nxt;
      s0_im_mag_r <= im_mag_nxt;
      s0_neg_re_r <= neg_re_nxt;
      s0_neg_im_r <= neg_im_nxt;
    end
  end

  // stage 1: partial products of the squares
  logic [PLW-1:0] s1_plo_re_r, s1_plo_im_r;
  logic [PHW-1:0] s1_phi_re_r, s1_phi_im_r;
  logic [W-1:0]   s1_re_mag_r, s1_im_mag_r;
  logic           s1_neg_re_r, s1_neg_im_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_plo_re_r <= PLW'(s0_re_mag_r) * PLW'(s0_re_mag_r[H-1:0]);
      s1_phi_re_r <= PHW'(s0_re_mag_r) * PHW'(s0_re_mag_r[W-1:H]);
      s1_plo_im_r <= PLW'(s0_im_mag_r) * PLW'(s0_im_mag_r[H-1:0]);
      s1_phi_im_r <= PHW'(s0_im_mag_r) * PHW'(s0_im_mag_r[W-1:H]);
      s1_re_mag_r <= s0_re_mag_r;
      s1_im_mag_r <= s0_im_mag_r;
      s1_neg_re_r <= s0_neg_re_r;
      s1_neg_im_r <= s0_neg_im_r;
    end
  end

  // stage 2: squares
  logic [SQW-1:0] s2_sq_re_r, s2_sq_im_r;
  logic [W-1:0]   s2_re_mag_r, s2_im_mag_r;
  logic           s2_neg_re_r, s2_neg_im_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_sq_re_r  <= SQW'(s1_plo_re_r) + (SQW'(s1_phi_re_r) << H);
      s2_sq_im_r  <= SQW'(s1_plo_im_r) + (SQW'(s1_phi_im_r) << H);
      s2_re_mag_r <= s1_re_mag_r;
      s2_im_mag_r <= s1_im_mag_r;
      s2_neg_re_r <= s1_neg_re_r;
      s2_neg_im_r <= s1_neg_im_r;
    end
  end

  // stage 3: denominator
  logic [DNW-1:0] s3_den_r;
  logic [W-1:0]   s3_re_mag_r, s3_im_mag_r;
  logic           s3_neg_re_r, s3_neg_im_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_den_r    <= DNW'(s2_sq_re_r) + DNW'(s2_sq_im_r) + gamma_al;
      s3_re_mag_r <= s2_re_mag_r;
      s3_im_mag_r <= s2_im_mag_r;
      s3_neg_re_r <= s2_neg_re_r;
      s3_neg_im_r <= s2_neg_im_r;
    end
  end

  // divider setup: top numerator bits as first remainder, overflow when they reach den
  rsr_pkg::div_stage_t div_r   [0:W];
  rsr_pkg::div_stage_t div_nxt [0:W];
  logic [NW-1:0]       num_re, num_im;
  logic [DNW-1:0]      rinit_re, rinit_im;

  always_comb begin
    num_re   = NW'(s3_re_mag_r) << DF;
    num_im   = NW'(s3_im_mag_r) << DF;
    rinit_re = DNW'(num_re[NW-1:W]);
    rinit_im = DNW'(num_im[NW-1:W]);
    div_nxt[0].den     = s3_den_r;
    div_nxt[0].dzero   = (s3_den_r == '0);
    div_nxt[0].rem_re  = rinit_re;
    div_nxt[0].rem_im  = rinit_im;
    div_nxt[0].nlow_re = num_re[W-1:0];
    div_nxt[0].nlow_im = num_im[W-1:0];
    div_nxt[0].q_re    = '0;
    div_nxt[0].q_im    = '0;
    div_nxt[0].ovf_re  = (rinit_re >= s3_den_r);
    div_nxt[0].ovf_im  = (rinit_im >= s3_den_r);
    div_nxt[0].neg_re  = s3_neg_re_r;
    div_nxt[0].neg_im  = s3_neg_im_r;
  end

  // restoring divider: one quotient bit per stage in each lane
  generate
    for (genvar j = 0; j < W; j++) begin : g_div
      logic [DNW:0] st_re, st_im;
      assign st_re = rsr_pkg::div_step(div_r[j].den, div_r[j].rem_re,
                                       div_r[j].nlow_re[W-1]);
      assign st_im = rsr_pkg::div_step(div_r[j].den, div_r[j].rem_im,
                                       div_r[j].nlow_im[W-1]);
      always_comb begin
        div_nxt[j+1]         = div_r[j];
        div_nxt[j+1].rem_re  = st_re[DNW-1:0];
        div_nxt[j+1].rem_im  = st_im[DNW-1:0];
        div_nxt[j+1].nlow_re = {div_r[j].nlow_re[W-2:0], 1'b0};
        div_nxt[j+1].nlow_im = {div_r[j].nlow_im[W-2:0], 1'b0};
        div_nxt[j+1].q_re    = {div_r[j].q_re[W-2:0], st_re[DNW]};
        div_nxt[j+1].q_im    = {div_r[j].q_im[W-2:0], st_im[DNW]};
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    for (int k = 0; k <= W; k++) begin
      if (en[DV0+k]) begin
        div_r[k] <= div_nxt[k];
      end
    end
  end

  // output stage: clip to range, apply sign, zero denominator override
  rsr_pkg::div_stage_t dl;
  logic [W-1:0] lim_re, lim_im, mag_re, mag_im;
  logic         sat_re, sat_im;
  logic [W-1:0] out_real_nxt, out_imag_nxt;
  logic         out_sat_nxt;
  logic [W-1:0] out_real_r, out_imag_r;
  logic         out_sat_r;

  always_comb begin
    dl     = div_r[W];
    lim_re = dl.neg_re ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    lim_im = dl.neg_im ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    sat_re = dl.ovf_re || (dl.q_re > lim_re);
    sat_im = dl.ovf_im || (dl.q_im > lim_im);
    mag_re = sat_re ? lim_re : dl.q_re;
    mag_im = sat_im ? lim_im : dl.q_im;
    if (dl.dzero) begin
      out_real_nxt = '0;
      out_imag_nxt = '0;
      out_sat_nxt  = 1'b1;
    end else begin
      out_real_nxt = dl.neg_re ? (~mag_re + 1'b1) : mag_re;
      out_imag_nxt = dl.neg_im ? (~mag_im + 1'b1) : mag_im;
      out_sat_nxt  = sat_re || sat_im;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      out_real_r <= out_real_nxt;
      out_imag_r <= out_imag_nxt;
      out_sat_r  <= out_sat_nxt;
    end
  end

  assign out_real      = out_real_r;
  assign out_imag      = out_imag_r;
  assign out_saturated = out_sat_r;

`ifndef ASSERT_OFF
  // an accepted request lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted request did not enter stage 0");

  // finished division leaves a remainder below the denominator
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST-2] && !dl.dzero && !dl.ovf_re && !dl.ovf_im
      |-> (dl.rem_re < dl.den) && (dl.rem_im < dl.den))
    else $error("divider remainder out of bound");

  // zero denominator gives zero result with the flag
  a_dzero_out: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST-2] && en[NST-1] && dl.dzero
      |=> out_valid && out_saturated && (out_real == '0) && (out_imag == '0))
    else $error("zero denominator not flagged");

  // quotient overflow always raises the flag
  a_ovf_flag: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST-2] && en[NST-1] && (dl.ovf_re || dl.ovf_im) |=> out_saturated)
    else $error("overflow without saturation flag");
`endif

endmodule

@@ tb/rsr_checker.sv @@
// checker for the regularized spectrum reciprocal: predicts each result request and compares it
module rsr_checker
  import rsr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [DATA_WIDTH-1:0] in_real_part,
  input  logic [DATA_WIDTH-1:0] in_imag_part,
  input  logic                  in_real_only,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [DATA_WIDTH-1:0] out_real,
  input  logic [DATA_WIDTH-1:0] out_imag,
  input  logic                  out_saturated,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  input  logic [31:0]           cfg_prdata,
  input  logic                  cfg_pready,
  output int unsigned           n_fail,
  output int unsigned           n_pending,
  output int unsigned           n_checked,
  output int unsigned           n_clipped
);

  localparam int W  = DATA_WIDTH;
  localparam int AW = 128;

  typedef struct packed {
    logic [W-1:0] re;
    logic [W-1:0] im;
    logic         sat;
  } recip_t;

  // reciprocals still owed by the block, oldest first
  recip_t             recip_q[$];
  logic [GAMMA_W-1:0] gamma_q;

  // magnitude of a two's complement value, exact for the most negative one
  function automatic logic [AW-1:0] mag_of(input logic [W-1:0] v);
    logic [W-1:0] m;
    m = v[W-1] ? (~v + 1'b1) : v;
    return AW'(m);
  endfunction

  // floored magnitude quotient, clipped to the signed range, then signed
  function automatic logic [W-1:0] div_clip(input logic [AW-1:0] mag, input logic neg,
                                            input logic [AW-1:0] den, inout logic sat);
    logic [AW-1:0] q;
    logic [AW-1:0] lim;
    q   = (mag << DEN_FRAC) / den;
    lim = (AW'(1) << (W - 1)) - (neg ? AW'(0) : AW'(1));
    if (q > lim) begin
      sat = 1'b1;
      q   = lim;
    end
    if (neg) begin
      q = ~q + 1'b1;
    end
    return q[W-1:0];
  endfunction

  // conj(z) / (|z|^2 + gamma), real-only bins drop the imaginary part
  function automatic recip_t calc_recip(input logic [W-1:0] re, input logic [W-1:0] im,
                                        input logic real_only, input logic [GAMMA_W-1:0] g);
    logic [AW-1:0] re_mag;
    logic [AW-1:0] im_mag;
    logic [AW-1:0] g_al;
    logic [AW-1:0] den;
    logic          sat;
    recip_t        r;
    re_mag = mag_of(re);
    im_mag = real_only ? '0 : mag_of(im);
    if (DEN_FRAC >= GAMMA_W) begin
      g_al = AW'(g) << (DEN_FRAC - GAMMA_W);
    end else begin
      g_al = AW'(g) >> (GAMMA_W - DEN_FRAC);
    end
    den = re_mag * re_mag + im_mag * im_mag + g_al;
    sat = 1'b0;
    if (den == '0) begin
      r.re  = '0;
      r.im  = '0;
      r.sat = 1'b1;
    end else begin
      r.re = div_clip(re_mag, re[W-1], den, sat);
      if (real_only) begin
        r.im = '0;
      end else begin
        // the conjugate flips the sign of a nonzero imaginary part
        r.im = div_clip(im_mag, !im[W-1] && (im_mag != '0), den, sat);
      end
      r.sat = sat;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    recip_t got;
    recip_t want;
    if (!rst_n) begin
      gamma_q = GAMMA_RESET;
      recip_q.delete();
    end else begin
      // register write
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[CFG_AW-1:2] == REG_GAMMA) begin
        gamma_q = cfg_pwdata[GAMMA_W-1:0];
      end
      // register read back
      if (cfg_psel && cfg_penable && !cfg_pwrite && cfg_pready &&
          cfg_paddr[CFG_AW-1:2] == REG_GAMMA && cfg_prdata[GAMMA_W-1:0] !== gamma_q) begin
        n_fail++;
        if (n_fail <= 10) begin
          $display("rsr_checker: gamma read back %h, expected %h", cfg_prdata, gamma_q);
        end
      end
      // result request, matched against the oldest expectation
      if (out_valid && out_ready) begin
        got = '{out_real, out_imag, out_saturated};
        if (recip_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) begin
            $display("rsr_checker: unexpected result re=%h im=%h sat=%b",
                     got.re, got.im, got.sat);
          end
        end else begin
          want = recip_q.pop_front();
          n_checked++;
          if (want.sat) begin
            n_clipped++;
          end
          if (got !== want) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("rsr_checker: mismatch exp re=%h im=%h sat=%b got re=%h im=%h sat=%b",
                       want.re, want.im, want.sat, got.re, got.im, got.sat);
            end
          end
        end
      end
      // coefficient request
      if (in_valid && in_ready) begin
        recip_q.push_back(calc_recip(in_real_part, in_imag_part, in_real_only, gamma_q));
      end
    end
    n_pending = recip_q.size();
  end

endmodule

@@ tb/tb_top.sv @@
// testbench top for the regularized spectrum reciprocal: stimulus, idling and verdict
module tb_top;
  import rsr_pkg::*;

  localparam int          W           = DATA_WIDTH;
  localparam int unsigned LIMIT       = 600000;
  localparam int          HOLD_CYCLES = 200;
  localparam int          N_PHASES    = 8;
  localparam int          PHASE_ITEMS = 228;
  // spare register index, writes to it are dropped
  localparam logic [0:0]  REG_SPARE   = 1'b1;
  localparam logic [W-1:0] D_MIN      = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] D_MAX      = ~D_MIN;
  localparam logic [W-1:0] ONE        = W'(1) << FRAC_BITS;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_ready;
  logic [W-1:0]      in_real_part  = '0;
  logic [W-1:0]      in_imag_part  = '0;
  logic              in_real_only  = 1'b0;
  logic              out_valid;
  logic              out_ready     = 1'b0;
  logic [W-1:0]      out_real;
  logic [W-1:0]      out_imag;
  logic              out_saturated;
  logic              cfg_psel      = 1'b0;
  logic              cfg_penable   = 1'b0;
  logic              cfg_pwrite    = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr     = '0;
  logic [31:0]       cfg_pwdata    = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  int unsigned n_fail;
  int unsigned n_pending;
  int unsigned n_checked;
  int unsigned n_clipped;
  int unsigned cycles        = 0;
  int unsigned n_real_only   = 0;
  int unsigned n_gamma_set   = 0;
  bit          idle_on       = 1'b1;
  bit          long_hold     = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  regularized_spectrum_reciprocal u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_real_part  (in_real_part),
    .in_imag_part  (in_imag_part),
    .in_real_only  (in_real_only),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_real      (out_real),
    .out_imag      (out_imag),
    .out_saturated (out_saturated),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready)
  );

  rsr_checker u_chk (.*);

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("tb_top: timeout after %0d cycles", cycles);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin : out_side
    int unsigned burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end else begin
        if (burst == 0 && idle_on && $urandom_range(0, 9) == 0) begin
          burst = $urandom_range(1, 16);
        end
        out_ready <= (burst == 0);
        if (burst != 0) begin
          burst--;
        end
      end
    end
  end

  // random coefficient part, weighted toward extremes, unity and small values
  function automatic logic [W-1:0] pick_part();
    logic [63:0]  raw;
    logic [W-1:0] v;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = D_MIN;
      2: v = D_MAX;
      3: v = W'(raw[7:0]);
      4: v = ONE + W'(raw[FRAC_BITS-3:0]);
      5: v = W'(raw >> $urandom_range(0, W - 1));
      6: v = W'(1);
      default: v = W'(raw);
    endcase
    if ($urandom_range(0, 1) == 1) begin
      v = ~v + 1'b1;
    end
    return v;
  endfunction

  // one coefficient request, valid held high until accepted
  task automatic put_coeff(input logic [W-1:0] re, input logic [W-1:0] im, input logic ro);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_real_part <= re;
    in_imag_part <= im;
    in_real_only <= ro;
    if (ro) begin
      n_real_only++;
    end
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering and wait for every owed result
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (n_pending != 0);
  endtask

  // register access: setup phase, then access phase
  task automatic reg_access(input logic wr, input logic [0:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    if (wr && idx == REG_GAMMA) begin
      n_gamma_set++;
    end
  endtask

  initial begin : stim
    logic [31:0] gamma_set [N_PHASES];
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    reg_access(1'b0, REG_GAMMA, '0);

    // reset gamma: extremes, unity, tiny values, garbage imag on real-only bins
    put_coeff('0, '0, 1'b0);
    put_coeff('0, '0, 1'b1);
    put_coeff(D_MIN, D_MIN, 1'b0);
    put_coeff(D_MAX, D_MAX, 1'b0);
    put_coeff(D_MIN, '0, 1'b1);
    put_coeff(D_MAX, '0, 1'b1);
    put_coeff('0, D_MIN, 1'b0);
    put_coeff(W'(1), '0, 1'b1);
    put_coeff(W'(1), W'(1), 1'b0);
    put_coeff('1, '1, 1'b0);
    put_coeff(ONE, '0, 1'b1);
    put_coeff(-ONE, ONE, 1'b0);
    put_coeff(W'(256), D_MAX, 1'b1);
    put_coeff(W'(2), W'(3), 1'b0);

    // zero gamma: zero denominator and overflow on both parts
    wait_drained();
    reg_access(1'b1, REG_GAMMA, 32'd0);
    reg_access(1'b0, REG_GAMMA, '0);
    put_coeff('0, '0, 1'b0);
    put_coeff('0, '0, 1'b1);
    put_coeff('0, D_MIN, 1'b1);
    put_coeff(W'(1), '0, 1'b1);
    put_coeff('1, '0, 1'b0);
    put_coeff('0, '1, 1'b0);
    put_coeff('0, W'(1), 1'b0);

    // largest gamma, then a write to the spare index that must not land
    wait_drained();
    reg_access(1'b1, REG_GAMMA, 32'hFFFF_FFFF);
    put_coeff('0, '0, 1'b0);
    put_coeff(W'(1), '0, 1'b1);
    wait_drained();
    reg_access(1'b1, REG_SPARE, 32'h1234_5678);
    reg_access(1'b0, REG_GAMMA, '0);
    put_coeff('0, '0, 1'b1);
    put_coeff(D_MIN, D_MAX, 1'b0);

    // random phases, each under its own gamma
    gamma_set = '{32'd1, 32'h8000_0000, $urandom, 32'd0, 32'd429,
                  $urandom_range(0, 65535), 32'hFFFF_FFFF, $urandom};
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      reg_access(1'b1, REG_GAMMA, gamma_set[ph]);
      idle_on = (ph != 3) && (ph != N_PHASES - 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // long output hold so the pipeline backs up into the input
        if (ph == 1 && k == 40) begin
          long_hold = 1'b1;
        end
        put_coeff(pick_part(), pick_part(), $urandom_range(0, 4) == 0);
      end
    end

    wait_drained();
    repeat (N_STAGES + 8) @(negedge clk);
    $display("tb_top: %0d coefficients checked (%0d real-only), %0d clipped or zero-denominator",
             n_checked, n_real_only, n_clipped);
    $display("tb_top: %0d gamma writes incl. zero and all-ones, one long output hold",
             n_gamma_set);
    if (n_fail == 0 && n_pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: %0d failures, %0d results missing", n_fail, n_pending);
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
